// ===== hw/rtl/vlbb_pkg.sv =====
package vlbb_pkg;

   localparam int COORD_W = 32;
   localparam int COUNT_W = 24;
   localparam int CMD_W   = 8;

   localparam logic [CMD_W-1:0] CMD_LINE_MOVE     = 8'd0;
   localparam logic [CMD_W-1:0] CMD_LINE_DRAW     = 8'd1;
   localparam logic [CMD_W-1:0] CMD_POLY_START    = 8'd2;
   localparam logic [CMD_W-1:0] CMD_POLY_MOVE     = 8'd3;
   localparam logic [CMD_W-1:0] CMD_POLY_DRAW     = 8'd4;
   localparam logic [CMD_W-1:0] CMD_POLY_END      = 8'd5;
   localparam logic [CMD_W-1:0] CMD_POLY_NORMAL   = 8'd6;
   localparam logic [CMD_W-1:0] CMD_TRI_START     = 8'd7;
   localparam logic [CMD_W-1:0] CMD_TRI_MOVE      = 8'd8;
   localparam logic [CMD_W-1:0] CMD_TRI_DRAW      = 8'd9;
   localparam logic [CMD_W-1:0] CMD_TRI_END       = 8'd10;
   localparam logic [CMD_W-1:0] CMD_TRI_NORMAL    = 8'd11;
   localparam logic [CMD_W-1:0] CMD_POINT_DRAW    = 8'd12;
   localparam logic [CMD_W-1:0] CMD_POINT_SIZE    = 8'd13;
   localparam logic [CMD_W-1:0] CMD_LINE_WIDTH    = 8'd14;
   localparam logic [CMD_W-1:0] CMD_DISPLAY_MAT   = 8'd15;
   localparam logic [CMD_W-1:0] CMD_MODEL_MAT     = 8'd16;
   localparam logic [CMD_W-1:0] CMD_LAST_KNOWN    = CMD_MODEL_MAT;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] ONE_UNIT  = 32'sh0001_0000;
   localparam logic [COUNT_W-1:0]        COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_item;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_x;
      logic signed [COORD_W-1:0] min_y;
      logic signed [COORD_W-1:0] min_z;
      logic signed [COORD_W-1:0] max_x;
      logic signed [COORD_W-1:0] max_y;
      logic signed [COORD_W-1:0] max_z;
      logic [COUNT_W-1:0]        item_count;
      logic                      display_used;
      logic                      error_seen;
      logic [CMD_W-1:0]          bad_command;
   } rsp_payload_type;

   typedef struct packed {
      logic               widen;
      logic               pad;
      logic [COUNT_W-1:0] count;
      logic               display;
      logic               failed;
      logic [CMD_W-1:0]   code;
   } ctrl_status_type;

   function automatic logic signed [COORD_W-1:0] pad_down(
      input logic signed [COORD_W-1:0] p);
      logic signed [COORD_W:0] diff;
      diff = {p[COORD_W-1], p} - {ONE_UNIT[COORD_W-1], ONE_UNIT};
      if (diff[COORD_W] != diff[COORD_W-1]) begin
         return COORD_MIN;
      end
      return diff[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] pad_up(
      input logic signed [COORD_W-1:0] p);
      logic signed [COORD_W:0] sum;
      sum = {p[COORD_W-1], p} + {ONE_UNIT[COORD_W-1], ONE_UNIT};
      if (sum[COORD_W] != sum[COORD_W-1]) begin
         return COORD_MAX;
      end
      return sum[COORD_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/vlbb_stream_if.sv =====
interface vlbb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/vlbb_axis.sv =====
module vlbb_axis (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic                                 widen,
   input  logic                                 pad,
   input  logic                                 clear,
   input  logic signed [vlbb_pkg::COORD_W-1:0]  point,
   output logic signed [vlbb_pkg::COORD_W-1:0]  low_next,
   output logic signed [vlbb_pkg::COORD_W-1:0]  high_next
);

   logic signed [vlbb_pkg::COORD_W-1:0] low_ff;
   logic signed [vlbb_pkg::COORD_W-1:0] high_ff;
   logic signed [vlbb_pkg::COORD_W-1:0] low_cand;
   logic signed [vlbb_pkg::COORD_W-1:0] high_cand;

   always_comb begin
      low_cand  = pad ? vlbb_pkg::pad_down(point) : point;
      high_cand = pad ? vlbb_pkg::pad_up(point) : point;
      low_next  = low_ff;
      high_next = high_ff;
      if (widen && (low_cand < low_ff)) begin
         low_next = low_cand;
      end
      if (widen && (high_cand > high_ff)) begin
         high_next = high_cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         low_ff  <= vlbb_pkg::COORD_MAX;
         high_ff <= vlbb_pkg::COORD_MIN;
      end else if (step) begin
         low_ff  <= low_next;
         high_ff <= high_next;
      end
   end

endmodule

// ===== hw/rtl/vlbb_ctrl.sv =====
module vlbb_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            clear,
   input  logic [vlbb_pkg::CMD_W-1:0]      command,
   output vlbb_pkg::ctrl_status_type       status
);

   logic                             skip_ff;
   logic                             skip_in;
   logic                             display_ff;
   logic                             failed_ff;
   logic [vlbb_pkg::CMD_W-1:0]       code_ff;
   logic [vlbb_pkg::COUNT_W-1:0]     count_ff;
   logic [vlbb_pkg::COUNT_W-1:0]     count_inc;

   assign count_inc = (count_ff == vlbb_pkg::COUNT_MAX) ? count_ff
                                                        : count_ff + 1'b1;

   always_comb begin
      skip_in        = skip_ff;
      status.widen   = 1'b0;
      status.pad     = 1'b0;
      status.count   = count_ff;
      status.display = display_ff;
      status.failed  = failed_ff;
      status.code    = code_ff;
      if (!failed_ff) begin
         if (skip_ff && (command != vlbb_pkg::CMD_MODEL_MAT)) begin
            status.count = count_inc;
         end else if (command > vlbb_pkg::CMD_LAST_KNOWN) begin
            status.failed = 1'b1;
            status.code   = command;
         end else begin
            skip_in      = 1'b0;
            status.count = count_inc;
            unique case (command) inside
               vlbb_pkg::CMD_LINE_MOVE, vlbb_pkg::CMD_LINE_DRAW,
               vlbb_pkg::CMD_POLY_MOVE, vlbb_pkg::CMD_POLY_DRAW,
               vlbb_pkg::CMD_POLY_END, vlbb_pkg::CMD_TRI_MOVE,
               vlbb_pkg::CMD_TRI_DRAW, vlbb_pkg::CMD_TRI_END: begin
                  status.widen = 1'b1;
               end
               vlbb_pkg::CMD_DISPLAY_MAT: begin
                  skip_in        = 1'b1;
                  status.display = 1'b1;
                  status.widen   = 1'b1;
                  status.pad     = 1'b1;
               end
               vlbb_pkg::CMD_POINT_DRAW: begin
                  status.widen = 1'b1;
                  status.pad   = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         skip_ff    <= 1'b0;
         display_ff <= 1'b0;
         failed_ff  <= 1'b0;
         code_ff    <= '0;
         count_ff   <= '0;
      end else if (step) begin
         skip_ff    <= skip_in;
         display_ff <= status.display;
         failed_ff  <= status.failed;
         code_ff    <= status.code;
         count_ff   <= status.count;
      end
   end

endmodule

// ===== hw/rtl/vector_list_bounding_box_unit.sv =====
// Channel   Direction  Payload            Transaction
// req_ch    in         command, xyz, last one drawing command
// rsp_ch    out        box, count, flags  one summary per list
//
// A command is registered on entry and then folded into the box state, so one
// transaction is taken per cycle unless the input stalls. The summary is written
// to an output register as the last command is folded in and is held there.
// Reset is synchronous and returns the box to empty and the command flags to zero.
// The input stalls only when a last command waits behind an untaken summary.
module vector_list_bounding_box_unit (
   input logic                 clock,
   input logic                 reset,
   vlbb_stream_if.sink         req_ch,
   vlbb_stream_if.source       rsp_ch
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   vlbb_pkg::req_payload_type         in_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   vlbb_pkg::rsp_payload_type         rsp_ff;
   logic                              advance;
   logic                              take_req;
   logic                              finish;
   vlbb_pkg::ctrl_status_type         status;
   logic signed [vlbb_pkg::COORD_W-1:0] low_next [3];
   logic signed [vlbb_pkg::COORD_W-1:0] high_next [3];
   logic signed [vlbb_pkg::COORD_W-1:0] point [3];

   assign advance  = in_valid_ff && (!in_ff.last_item || !rsp_valid_ff || rsp_ch.ready);
   assign finish   = advance && in_ff.last_item;
   assign take_req = req_ch.valid && req_ch.ready;

   assign req_ch.ready   = !in_valid_ff || advance;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign point[0] = in_ff.point_x;
   assign point[1] = in_ff.point_y;
   assign point[2] = in_ff.point_z;

   assign in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = finish ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   vlbb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .clear   (in_ff.last_item),
      .command (in_ff.command),
      .status  (status)
   );

   for (genvar a = 0; a < 3; a++) begin : g_axis
      vlbb_axis u_axis (
         .clock     (clock),
         .reset     (reset),
         .step      (advance),
         .widen     (status.widen),
         .pad       (status.pad),
         .clear     (in_ff.last_item),
         .point     (point[a]),
         .low_next  (low_next[a]),
         .high_next (high_next[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_ff <= req_ch.payload;
      end
      if (finish) begin
         rsp_ff.min_x        <= low_next[0];
         rsp_ff.min_y        <= low_next[1];
         rsp_ff.min_z        <= low_next[2];
         rsp_ff.max_x        <= high_next[0];
         rsp_ff.max_y        <= high_next[1];
         rsp_ff.max_z        <= high_next[2];
         rsp_ff.item_count   <= status.count;
         rsp_ff.display_used <= status.display;
         rsp_ff.error_seen   <= status.failed;
         rsp_ff.bad_command  <= status.failed ? status.code : '0;
      end
   end

endmodule

// ===== hw/rtl/vlbb_checker.sv =====
module vlbb_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input vlbb_pkg::rsp_payload_type rsp_payload
);

   logic x_empty;
   logic y_empty;
   logic z_empty;

   assign x_empty = (rsp_payload.min_x == vlbb_pkg::COORD_MAX) &&
                    (rsp_payload.max_x == vlbb_pkg::COORD_MIN);
   assign y_empty = (rsp_payload.min_y == vlbb_pkg::COORD_MAX) &&
                    (rsp_payload.max_y == vlbb_pkg::COORD_MIN);
   assign z_empty = (rsp_payload.min_z == vlbb_pkg::COORD_MAX) &&
                    (rsp_payload.max_z == vlbb_pkg::COORD_MIN);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("summary dropped before it was taken");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("summary shown right after reset");

   a_code_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.error_seen |-> rsp_payload.bad_command == '0)
      else $error("error code reported without an error");

   a_code_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_seen |->
         rsp_payload.bad_command > vlbb_pkg::CMD_LAST_KNOWN)
      else $error("a known command was reported as an error");

   a_box_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (x_empty || y_empty || z_empty) |-> x_empty && y_empty && z_empty)
      else $error("box is empty on some axes only");

endmodule

bind vector_list_bounding_box_unit vlbb_checker u_vlbb_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
